/* rtl/core/qap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap_pkg
// shared types, constants and helpers for the quad attitude pid block
// ----------------------------------------------------------------------------
package qap_pkg;

    localparam int THR_W    = 12;
    localparam int ANG_W    = 9;
    localparam int BASE_W   = 10;
    localparam int CMD_W    = 16;
    localparam int INTEG_W  = 16;
    localparam int GAIN_W   = 4;
    localparam int LIMIT_W  = 10;
    localparam int DBAND_W  = 4;
    localparam int START_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int N_CHAN   = 4;

    // throttle mapping
    localparam int MAP_IN_LO  = 989;
    localparam int MAP_IN_HI  = 1967;
    localparam int MAP_OUT_LO = 55;
    localparam int MAP_OUT_HI = 182;
    localparam int MAP_DIV    = MAP_IN_HI - MAP_IN_LO;
    localparam int RECIP_SH   = 29;
    localparam int RECIP_W    = 20;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(MAP_DIV) - 64'd1) / 64'(MAP_DIV));

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DEADBAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_SAMPLES = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] integral_limit;
        logic [DBAND_W-1:0] level_deadband;
        logic [START_W-1:0] startup_samples;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:       4'd3,
        integ_gain:      4'd1,
        deriv_gain:      4'd1,
        integral_limit:  10'd180,
        level_deadband:  4'd2,
        startup_samples: 8'd60
    };

    // per channel behavior
    typedef struct packed {
        logic half_err;    // integrate error/2
        logic zero_clear;  // clear integral only on zero error
        logic neg_prop;    // negate proportional term
    } t_chan_mode;

    localparam t_chan_mode CHAN_MODE [N_CHAN] = '{
        '{half_err: 1'b1, zero_clear: 1'b0, neg_prop: 1'b0},  // pitch+
        '{half_err: 1'b1, zero_clear: 1'b1, neg_prop: 1'b0},  // pitch-
        '{half_err: 1'b0, zero_clear: 1'b0, neg_prop: 1'b1},  // roll-
        '{half_err: 1'b0, zero_clear: 1'b0, neg_prop: 1'b0}   // roll+
    };

    // 9-bit negate, most negative value maps to the maximum
    function automatic logic signed [ANG_W-1:0] neg_ang(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v == {1'b1, {(ANG_W-1){1'b0}}}) begin
            r = {1'b0, {(ANG_W-1){1'b1}}};
        end else begin
            r = -v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/qap_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap interfaces
// request, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface qap_in_if import qap_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic [THR_W-1:0]          throttle_pulse;
    logic signed [ANG_W-1:0]   pitch_deg;
    logic signed [ANG_W-1:0]   roll_deg;
    logic                      new_sample;

    modport source (output valid, throttle_pulse, pitch_deg, roll_deg, new_sample,
                    input ready);
    modport sink   (input valid, throttle_pulse, pitch_deg, roll_deg, new_sample,
                    output ready);
endinterface

interface qap_out_if import qap_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [BASE_W-1:0]  base_command;
    logic                      pid_active;
    logic signed [CMD_W-1:0]   pitch_pos_out;
    logic signed [CMD_W-1:0]   pitch_neg_out;
    logic signed [CMD_W-1:0]   roll_neg_out;
    logic signed [CMD_W-1:0]   roll_pos_out;

    modport source (output valid, base_command, pid_active, pitch_pos_out,
                    pitch_neg_out, roll_neg_out, roll_pos_out, input ready);
    modport sink   (input valid, base_command, pid_active, pitch_pos_out,
                    pitch_neg_out, roll_neg_out, roll_pos_out, output ready);
endinterface

interface qap_cfg_if import qap_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/qap_base_map.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap_base_map
// linear throttle to base command map, division by reciprocal multiply
// ----------------------------------------------------------------------------
module qap_base_map import qap_pkg::*; (
    input  wire logic [THR_W-1:0]         i_throttle,
    output logic signed [BASE_W-1:0]      o_base
);

    localparam int DIFF_W = THR_W + 1;
    localparam int PROD_W = DIFF_W + 7;
    localparam int MAG_W  = PROD_W - 1;
    localparam int FULL_W = MAG_W + RECIP_W;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic [MAG_W-1:0]         mag;
    logic [FULL_W-1:0]        scaled;
    logic [BASE_W-1:0]        quot;
    logic signed [BASE_W-1:0] squot;

    always_comb begin
        diff   = $signed({1'b0, i_throttle}) - DIFF_W'(MAP_IN_LO);
        // times (182 - 55) = 127
        prod   = (PROD_W'(diff) <<< 7) - PROD_W'(diff);
        mag    = prod[PROD_W-1] ? MAG_W'(-prod) : prod[MAG_W-1:0];
        // exact floor(mag / 978) over the whole input range
        scaled = FULL_W'(mag) * FULL_W'(RECIP);
        quot   = scaled[RECIP_SH +: BASE_W];
        squot  = prod[PROD_W-1] ? -$signed(quot) : $signed(quot);
        o_base = squot + BASE_W'(MAP_OUT_LO);
    end

endmodule

`default_nettype wire

/* rtl/core/qap_pid_channel.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qap_pid_channel
// one pid channel: integral update with clamps and deadband, base + (p+i+d)/2 output
// ----------------------------------------------------------------------------
module qap_pid_channel import qap_pkg::*; (
    input  wire t_chan_mode               i_mode,
    input  wire t_cfg                     i_cfg,
    input  wire logic signed [ANG_W-1:0]  i_err,
    input  wire logic signed [ANG_W-1:0]  i_last_err,
    input  wire logic signed [INTEG_W-1:0] i_integ,
    input  wire logic signed [BASE_W-1:0] i_base,
    output logic signed [INTEG_W-1:0]     o_integ,
    output logic signed [CMD_W-1:0]       o_cmd
);

    localparam int ISUM_W = INTEG_W + 2;
    localparam int P_W    = ANG_W + GAIN_W + 1;
    localparam int I_W    = INTEG_W + GAIN_W + 1;
    localparam int DD_W   = ANG_W + 1;
    localparam int D_W    = DD_W + GAIN_W + 1;
    localparam int SUM_W  = I_W + 2;

    logic signed [ANG_W-1:0]   step;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [ISUM_W-1:0]  iclamp;
    logic [ANG_W:0]            mag;
    logic                      clear;
    logic signed [P_W-1:0]     p_term;
    logic signed [I_W-1:0]     i_term;
    logic signed [DD_W-1:0]    dd;
    logic signed [D_W-1:0]     d_term;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   half;

    always_comb begin
        // error/2 truncated toward zero
        step = i_mode.half_err
             ? ((i_err + $signed({{(ANG_W-1){1'b0}}, i_err[ANG_W-1]})) >>> 1)
             : i_err;
        isum = ISUM_W'(i_integ) + ISUM_W'(step);
        if (isum >= $signed({{(ISUM_W-LIMIT_W){1'b0}}, i_cfg.integral_limit})) begin
            iclamp = $signed({{(ISUM_W-LIMIT_W){1'b0}}, i_cfg.integral_limit});
        end else if (isum < -ISUM_W'(32768)) begin
            iclamp = -ISUM_W'(32768);
        end else begin
            iclamp = isum;
        end
        mag   = i_err[ANG_W-1] ? (ANG_W+1)'(-(ANG_W+1)'(i_err)) : {1'b0, i_err};
        clear = i_mode.zero_clear ? (i_err == '0)
                                  : (mag < {{(ANG_W+1-DBAND_W){1'b0}}, i_cfg.level_deadband});
        o_integ = clear ? '0 : iclamp[INTEG_W-1:0];

        p_term = P_W'(i_err) * $signed({1'b0, i_cfg.prop_gain});
        if (i_mode.neg_prop) begin
            p_term = -p_term;
        end
        i_term = I_W'(o_integ) * $signed({1'b0, i_cfg.integ_gain});
        dd     = DD_W'(i_err) - DD_W'(i_last_err);
        d_term = D_W'(dd) * $signed({1'b0, i_cfg.deriv_gain});

        sum  = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term)
             + (SUM_W'(i_base) <<< 1);
        half = (sum + $signed({{(SUM_W-1){1'b0}}, sum[SUM_W-1]})) >>> 1;
        if (half > SUM_W'(32767)) begin
            o_cmd = 16'sh7fff;
        end else if (half < -SUM_W'(32768)) begin
            o_cmd = 16'sh8000;
        end else begin
            o_cmd = half[CMD_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/quad_attitude_pid.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_attitude_pid
// quadcopter attitude pid: throttle map and four pid channels per request
// ----------------------------------------------------------------------------
// One request per clock while the sink takes results: a request is captured
// in the input register together with its mapped throttle; once the result
// register can take it, the four pid channels run on the held angles, update
// integrals and last errors once active, and load the result register. The
// sustained rate is one request per cycle while the sink is ready, set by the
// single state update in the pid stage; while a result waits for the sink the
// input register can take one more request, then input stalls. Registers are
// written through the configuration channel, which is always ready.
module quad_attitude_pid import qap_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    qap_in_if.sink      i_in,
    qap_out_if.source   o_out,
    qap_cfg_if.sink     i_cfg
);

    t_cfg                       r_cfg;

    // input stage
    logic                       r_in_valid;
    logic signed [BASE_W-1:0]   r_base;
    logic signed [ANG_W-1:0]    r_pitch_in;
    logic signed [ANG_W-1:0]    r_roll_in;
    logic                       r_new;

    // controller state
    logic signed [ANG_W-1:0]    r_held_pitch;
    logic signed [ANG_W-1:0]    r_held_roll;
    logic [COUNT_W-1:0]         r_count;
    logic signed [INTEG_W-1:0]  r_integ [N_CHAN];
    logic signed [ANG_W-1:0]    r_last  [N_CHAN];

    // result stage
    logic                       r_out_valid;
    logic signed [BASE_W-1:0]   r_out_base;
    logic                       r_out_active;
    logic signed [CMD_W-1:0]    r_out_cmd [N_CHAN];

    logic                       advance;
    logic                       fire;
    logic signed [BASE_W-1:0]   base_map;
    logic signed [ANG_W-1:0]    n_held_pitch;
    logic signed [ANG_W-1:0]    n_held_roll;
    logic [COUNT_W-1:0]         n_count;
    logic                       active;
    logic signed [ANG_W-1:0]    err      [N_CHAN];
    logic signed [INTEG_W-1:0]  integ_nx [N_CHAN];
    logic signed [CMD_W-1:0]    cmd      [N_CHAN];

    assign advance     = !r_out_valid || o_out.ready;
    assign fire        = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    qap_base_map u_base_map (
        .i_throttle (i_in.throttle_pulse),
        .o_base     (base_map)
    );

    always_comb begin
        n_held_pitch = r_new ? r_pitch_in : r_held_pitch;
        n_held_roll  = r_new ? r_roll_in  : r_held_roll;
        n_count      = (r_new && r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
        active       = n_count > {1'b0, r_cfg.startup_samples};
        err[0]       = n_held_pitch;
        err[1]       = neg_ang(n_held_pitch);
        err[2]       = neg_ang(n_held_roll);
        err[3]       = n_held_roll;
    end

    for (genvar c = 0; c < N_CHAN; c++) begin : g_chan
        qap_pid_channel u_chan (
            .i_mode     (CHAN_MODE[c]),
            .i_cfg      (r_cfg),
            .i_err      (err[c]),
            .i_last_err (r_last[c]),
            .i_integ    (r_integ[c]),
            .i_base     (r_base),
            .o_integ    (integ_nx[c]),
            .o_cmd      (cmd[c])
        );
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PROP_GAIN:       r_cfg.prop_gain       <= i_cfg.data[GAIN_W-1:0];
                REG_INTEG_GAIN:      r_cfg.integ_gain      <= i_cfg.data[GAIN_W-1:0];
                REG_DERIV_GAIN:      r_cfg.deriv_gain      <= i_cfg.data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT:  r_cfg.integral_limit  <= i_cfg.data[LIMIT_W-1:0];
                REG_LEVEL_DEADBAND:  r_cfg.level_deadband  <= i_cfg.data[DBAND_W-1:0];
                REG_STARTUP_SAMPLES: r_cfg.startup_samples <= i_cfg.data[START_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_base     <= base_map;
            r_pitch_in <= i_in.pitch_deg;
            r_roll_in  <= i_in.roll_deg;
            r_new      <= i_in.new_sample;
        end
    end

    // state update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_pitch <= '0;
            r_held_roll  <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            for (int c = 0; c < N_CHAN; c++) begin
                r_integ[c] <= '0;
                r_last[c]  <= '0;
            end
        end else begin
            if (fire) begin
                r_held_pitch <= n_held_pitch;
                r_held_roll  <= n_held_roll;
                r_count      <= n_count;
                if (active) begin
                    for (int c = 0; c < N_CHAN; c++) begin
                        r_integ[c] <= integ_nx[c];
                        r_last[c]  <= err[c];
                    end
                end
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_base   <= r_base;
            r_out_active <= active;
            for (int c = 0; c < N_CHAN; c++) begin
                r_out_cmd[c] <= active ? cmd[c] : '0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.base_command  = r_out_base;
    assign o_out.pid_active    = r_out_active;
    assign o_out.pitch_pos_out = r_out_cmd[0];
    assign o_out.pitch_neg_out = r_out_cmd[1];
    assign o_out.roll_neg_out  = r_out_cmd[2];
    assign o_out.roll_pos_out  = r_out_cmd[3];

    // held-off results carry zero commands
    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.pid_active |->
            o_out.pitch_pos_out == '0 && o_out.pitch_neg_out == '0 &&
            o_out.roll_neg_out == '0 && o_out.roll_pos_out == '0)
        else $error("pid commands nonzero while held off");

    // sample count only grows outside reset
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("sample count went backwards");

    // mapped throttle stays inside the range the map reaches over all 12-bit inputs
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.base_command >= -10'sd73 && o_out.base_command <= 10'sd458)
        else $error("base command outside mapped range");

endmodule

`default_nettype wire
